// ----- hdl/lrcs_pkg.sv -----
// shared types and codes for the least-run-count scheduler
package lrcs_pkg;

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_SLEEPING = 3'd3,
    ST_EXITED   = 3'd4
  } task_state_t;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_SPAWN    = 2'd1,
    OP_SLEEP    = 2'd2,
    OP_QUERY    = 2'd3
  } opcode_t;

  localparam logic [1:0] RC_OK       = 2'd0;
  localparam logic [1:0] RC_NO_SLOT  = 2'd1;
  localparam logic [1:0] RC_NO_READY = 2'd2;

  localparam logic [15:0] FIRST_PID = 16'd2;

  typedef enum logic [3:0] {
    C_IDLE,
    C_PARK,
    C_WAKE,
    C_REQUEUE,
    C_SORT_LOAD,
    C_SORT_CMP,
    C_PICK,
    C_SPAWN_SCAN,
    C_SPAWN_DONE,
    C_QUERY,
    C_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic start;      // latch input word
    logic park;       // park running task
    logic wake_step;  // examine one sleeper
    logic requeue;    // push running task
    logic sort_load;  // load insertion key
    logic sort_step;  // one compare/shift
    logic pick;       // dequeue head
    logic scan_step;  // examine one slot for spawn
    logic spawn_do;   // commit spawn
    logic query;      // report running task
  } cmd_t;

  typedef struct packed {
    logic wake_done;
    logic need_requeue;
    logic sort_done;
    logic key_done;
    logic scan_done;
  } stat_t;

endpackage

// ----- hdl/lrcs_ctrl.sv -----
// controller state machine for the scheduler
module lrcs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic [1:0]       opcode,
  input  lrcs_pkg::stat_t  stat,
  output lrcs_pkg::cmd_t   cmd
);
  import lrcs_pkg::*;

  ctrl_state_t state, state_next;
  logic        ov, ov_next;
  logic [1:0]  op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      ov    <= 1'b0;
      op    <= OP_SCHEDULE;
    end else begin
      state <= state_next;
      ov    <= ov_next;
      if (in_valid && in_ready) op <= opcode;
    end
  end

  assign out_valid = ov;
  assign in_ready  = (state == C_IDLE) && !ov;

  always_comb begin
    state_next = state;
    ov_next    = ov;
    cmd        = '0;
    if (ov && out_ready) ov_next = 1'b0;
    case (state)
      C_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.start = 1'b1;
          case (opcode)
            OP_SCHEDULE: state_next = C_WAKE;
            OP_SPAWN:    state_next = C_SPAWN_SCAN;
            OP_SLEEP:    state_next = C_PARK;
            default:     state_next = C_QUERY;
          endcase
        end
      end
      C_PARK: begin
        cmd.park   = 1'b1;
        state_next = C_WAKE;
      end
      C_WAKE: begin
        if (stat.wake_done) begin
          state_next = stat.need_requeue ? C_REQUEUE : C_PICK;
        end else begin
          cmd.wake_step = 1'b1;
        end
      end
      C_REQUEUE: begin
        cmd.requeue = 1'b1;
        state_next  = C_SORT_LOAD;
      end
      C_SORT_LOAD: begin
        if (stat.sort_done) state_next = C_PICK;
        else begin
          cmd.sort_load = 1'b1;
          state_next    = C_SORT_CMP;
        end
      end
      C_SORT_CMP: begin
        cmd.sort_step = 1'b1;
        if (stat.key_done) state_next = C_SORT_LOAD;
      end
      C_PICK: begin
        cmd.pick   = 1'b1;
        state_next = C_OUT;
      end
      C_SPAWN_SCAN: begin
        if (stat.scan_done) state_next = C_SPAWN_DONE;
        else cmd.scan_step = 1'b1;
      end
      C_SPAWN_DONE: begin
        cmd.spawn_do = 1'b1;
        state_next   = C_OUT;
      end
      C_QUERY: begin
        cmd.query  = 1'b1;
        state_next = C_OUT;
      end
      C_OUT: begin
        ov_next    = 1'b1;
        state_next = C_IDLE;
      end
      default: state_next = C_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) ov && !out_ready |=> ov)
    else $error("result word dropped");
  assert property (@(posedge clk) disable iff (rst) state == C_OUT |=> ov)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !ov)
    else $error("accept while result pending");
  assert property (@(posedge clk) disable iff (rst)
    state == C_PARK |-> op == OP_SLEEP)
    else $error("park outside sleep");
endmodule

// ----- hdl/lrcs_dp.sv -----
// task tables, queues and result registers of the scheduler
module lrcs_dp #(
  parameter int NUM_TASKS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      now,
  input  logic [31:0]      sleep_ticks,
  input  lrcs_pkg::cmd_t   cmd,
  output lrcs_pkg::stat_t  stat,
  output logic [1:0]       status_code,
  output logic [3:0]       slot,
  output logic [15:0]      pid
);
  import lrcs_pkg::*;

  localparam int SW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CW = $clog2(NUM_TASKS + 1);
  localparam logic [CW-1:0] NT = CW'(NUM_TASKS);

  task_state_t       tstat [NUM_TASKS];
  logic [31:0]       rcnt  [NUM_TASKS];
  logic [31:0]       wake  [NUM_TASKS];
  logic [15:0]       tpid  [NUM_TASKS];
  logic [SW-1:0]     rq    [NUM_TASKS];
  logic [SW-1:0]     sq    [NUM_TASKS];
  logic [CW-1:0]     rcount, scount;
  logic [SW-1:0]     run_slot;
  logic              run_valid;
  logic [15:0]       next_pid;

  logic [31:0]       now_r, ticks_r;
  logic [CW-1:0]     widx, kept;   // wake walk
  logic [CW-1:0]     si, sj;       // insertion sort
  logic [SW-1:0]     key;
  logic [31:0]       kc;
  logic [CW-1:0]     scan;
  logic              found;

  logic [SW-1:0]     ws;
  logic [SW-1:0]     prev;
  logic              do_shift;

  assign ws       = sq[widx[SW-1:0]];
  assign prev     = rq[SW'(sj - 1'b1)];
  assign do_shift = (sj != '0) && (rcnt[prev] > kc);

  assign stat.wake_done    = (widx >= scount);
  assign stat.need_requeue = run_valid && (tstat[run_slot] == ST_RUNNING);
  assign stat.sort_done    = (si >= rcount);
  assign stat.key_done     = !do_shift;
  assign stat.scan_done    = found || (scan == NT);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        tstat[i] <= ST_UNUSED;
        rcnt[i]  <= '0;
        wake[i]  <= '0;
        tpid[i]  <= '0;
      end
      rcount    <= '0;
      scount    <= '0;
      run_slot  <= '0;
      run_valid <= 1'b0;
      next_pid  <= FIRST_PID;
      widx <= '0; kept <= '0; si <= '0; sj <= '0; scan <= '0; found <= 1'b0;
    end else begin
      if (cmd.start) begin
        now_r <= now; ticks_r <= sleep_ticks;
        widx <= '0; kept <= '0; si <= CW'(1); scan <= '0; found <= 1'b0;
      end
      if (cmd.park && run_valid && tstat[run_slot] == ST_RUNNING && scount < NT) begin
        tstat[run_slot]        <= ST_SLEEPING;
        wake[run_slot]         <= now_r + ticks_r;
        sq[scount[SW-1:0]]     <= run_slot;
        scount                 <= scount + 1'b1;
      end
      if (cmd.wake_step) begin
        widx <= widx + 1'b1;
        if (now_r >= wake[ws]) begin
          tstat[ws] <= ST_READY;
          wake[ws]  <= '0;
          if (rcount < NT) begin
            rq[rcount[SW-1:0]] <= ws;
            rcount <= rcount + 1'b1;
          end
        end else begin
          sq[kept[SW-1:0]] <= ws;
          kept <= kept + 1'b1;
        end
        if (widx + 1'b1 >= scount) scount <= (now_r >= wake[ws]) ? kept : kept + 1'b1;
      end
      if (cmd.requeue) begin
        tstat[run_slot] <= ST_READY;
        if (rcount < NT) begin
          rq[rcount[SW-1:0]] <= run_slot;
          rcount <= rcount + 1'b1;
        end
      end
      if (cmd.sort_load) begin
        key <= rq[si[SW-1:0]];
        kc  <= rcnt[rq[si[SW-1:0]]];
        sj  <= si;
      end
      if (cmd.sort_step) begin
        if (do_shift) begin
          rq[sj[SW-1:0]] <= prev;
          sj <= sj - 1'b1;
        end else begin
          rq[sj[SW-1:0]] <= key;
          si <= si + 1'b1;
        end
      end
      if (cmd.pick) begin
        if (rcount == '0) begin
          run_valid   <= 1'b0;
          status_code <= RC_NO_READY; slot <= '0; pid <= '0;
        end else begin
          for (int i = 0; i < NUM_TASKS - 1; i++) rq[i] <= rq[i+1];
          rcount         <= rcount - 1'b1;
          rcnt[rq[0]]    <= rcnt[rq[0]] + 32'd1;
          tstat[rq[0]]   <= ST_RUNNING;
          run_slot       <= rq[0];
          run_valid      <= 1'b1;
          status_code    <= RC_OK;
          slot           <= 4'(rq[0]);
          pid            <= tpid[rq[0]];
        end
      end
      if (cmd.scan_step) begin
        if (tstat[scan[SW-1:0]] == ST_UNUSED || tstat[scan[SW-1:0]] == ST_EXITED)
          found <= 1'b1;
        else scan <= scan + 1'b1;
      end
      if (cmd.spawn_do) begin
        if (!found) begin
          status_code <= RC_NO_SLOT; slot <= '0; pid <= '0;
        end else begin
          tstat[scan[SW-1:0]] <= ST_READY;
          rcnt[scan[SW-1:0]]  <= rcnt[0];
          tpid[scan[SW-1:0]]  <= next_pid;
          next_pid            <= next_pid + 16'd1;
          if (rcount < NT) begin
            rq[rcount[SW-1:0]] <= scan[SW-1:0];
            rcount <= rcount + 1'b1;
          end
          status_code <= RC_OK;
          slot        <= 4'(scan);
          pid         <= next_pid;
        end
      end
      if (cmd.query) begin
        if (run_valid) begin
          status_code <= RC_OK; slot <= 4'(run_slot); pid <= tpid[run_slot];
        end else begin
          status_code <= RC_NO_READY; slot <= '0; pid <= '0;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) rcount <= NT)
    else $error("ready queue overflow");
  assert property (@(posedge clk) disable iff (rst) scount <= NT)
    else $error("sleep queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    cmd.pick && rcount != '0 |=> run_valid)
    else $error("pick did not start a task");
endmodule

// ----- hdl/least_run_count_task_scheduler_core.sv -----
// top level of the least-run-count task scheduler
// schedule: walk the sleepers, requeue and insertion-sort the running task if it still runs, then pick
// sort: each key is loaded, then compared and shifted until it settles; sleep first parks; spawn scans for a free slot
// throughput: one word at a time; next word taken after the result is taken
// reset: synchronous rst empties all queues, clears slots, next pid starts at 2
// the result register holds a finished word until out_ready
module least_run_count_task_scheduler_core #(
  parameter int NUM_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] now,
  input  logic [31:0] sleep_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status_code,
  output logic [3:0]  slot,
  output logic [15:0] pid
);
  import lrcs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lrcs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .opcode(opcode),
    .stat(stat), .cmd(cmd)
  );

  lrcs_dp #(.NUM_TASKS(NUM_TASKS)) u_dp (
    .clk(clk), .rst(rst), .now(now), .sleep_ticks(sleep_ticks),
    .cmd(cmd), .stat(stat), .status_code(status_code), .slot(slot), .pid(pid)
  );
endmodule

// ----- dv/least_run_count_task_scheduler_core_tb.sv -----
// self-checking testbench for the least-run-count task scheduler core
`timescale 1ns / 1ps
module least_run_count_task_scheduler_core_tb;
  import lrcs_pkg::*;

  localparam int NT = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [31:0] now = '0;
  logic [31:0] sleep_ticks = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status_code;
  logic [3:0]  slot;
  logic [15:0] pid;

  least_run_count_task_scheduler_core #(.NUM_TASKS(NT)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .now(now), .sleep_ticks(sleep_ticks),
    .out_valid(out_valid), .out_ready(out_ready),
    .status_code(status_code), .slot(slot), .pid(pid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0]  code;
    logic [3:0]  slot;
    logic [15:0] pid;
  } sched_reply_t;

  // scheduler shadow state
  task_state_t  m_state [NT];
  logic [31:0]  m_runs [NT];
  logic [31:0]  m_wake [NT];
  logic [15:0]  m_pid [NT];
  int           m_readyq [$];
  int           m_sleepq [$];
  int           m_cur;
  bit           m_cur_ok;
  logic [15:0]  m_next_pid;

  sched_reply_t pending_replies [$];
  int  error_count = 0;
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;
  bit  burst_on = 1'b1;
  int  rand_now = 0;
  logic [31:0] clock_now = '0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic sched_reply_t pick_next(input logic [31:0] t);
    sched_reply_t r;
    int kept [$];
    int s;
    int j;
    kept = {};
    foreach (m_sleepq[i]) begin
      s = m_sleepq[i];
      if (t >= m_wake[s]) begin
        m_state[s] = ST_READY;
        m_wake[s] = '0;
        if (m_readyq.size() < NT) m_readyq.push_back(s);
      end else begin
        kept.push_back(s);
      end
    end
    m_sleepq = kept;
    if (m_cur_ok && m_state[m_cur] == ST_RUNNING) begin
      m_state[m_cur] = ST_READY;
      if (m_readyq.size() < NT) m_readyq.push_back(m_cur);
      for (int i = 1; i < m_readyq.size(); i++) begin
        s = m_readyq[i];
        j = i;
        while (j > 0 && m_runs[m_readyq[j-1]] > m_runs[s]) begin
          m_readyq[j] = m_readyq[j-1];
          j--;
        end
        m_readyq[j] = s;
      end
    end
    if (m_readyq.size() == 0) begin
      m_cur_ok = 1'b0;
      r = '{RC_NO_READY, 4'd0, 16'd0};
      return r;
    end
    s = m_readyq.pop_front();
    m_runs[s] = m_runs[s] + 32'd1;
    m_state[s] = ST_RUNNING;
    m_cur = s;
    m_cur_ok = 1'b1;
    r = '{RC_OK, 4'(s), m_pid[s]};
    return r;
  endfunction

  function automatic sched_reply_t predict_reply(input opcode_t op, input logic [31:0] t,
                                                 input logic [31:0] ticks);
    sched_reply_t r;
    int s;
    case (op)
      OP_SCHEDULE: r = pick_next(t);
      OP_SPAWN: begin
        s = NT;
        for (int i = NT - 1; i >= 0; i--)
          if (m_state[i] == ST_UNUSED || m_state[i] == ST_EXITED) s = i;
        if (s == NT) begin
          r = '{RC_NO_SLOT, 4'd0, 16'd0};
        end else begin
          m_state[s] = ST_READY;
          m_runs[s] = m_runs[0];
          m_pid[s] = m_next_pid;
          m_next_pid = m_next_pid + 16'd1;
          if (m_readyq.size() < NT) m_readyq.push_back(s);
          r = '{RC_OK, 4'(s), m_pid[s]};
        end
      end
      OP_SLEEP: begin
        if (m_cur_ok && m_state[m_cur] == ST_RUNNING && m_sleepq.size() < NT) begin
          m_state[m_cur] = ST_SLEEPING;
          m_wake[m_cur] = t + ticks;
          m_sleepq.push_back(m_cur);
        end
        r = pick_next(t);
      end
      default: begin
        if (m_cur_ok) r = '{RC_OK, 4'(m_cur), m_pid[m_cur]};
        else r = '{RC_NO_READY, 4'd0, 16'd0};
      end
    endcase
    return r;
  endfunction

  // valid stays up after an accept until the next call drives the next word or a gap
  task automatic send_word(input opcode_t op, input logic [31:0] t, input logic [31:0] ticks);
    if (!burst_on) begin
      in_valid <= 1'b0;
      while (!burst_on) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    now <= t;
    sleep_ticks <= ticks;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_replies.push_back(predict_reply(op, t, ticks));
  endtask

  // sender burst pattern
  initial begin
    int n;
    forever begin
      n = $urandom_range(1, 30);
      burst_on = 1'b1;
      repeat (n) @(posedge clk);
      if ($urandom_range(0, 3) != 0) begin
        burst_on = 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 9) < 6) || (rand_now[4:3] == 2'b00);
    rand_now <= rand_now + 1;
  end

  // result check
  always @(posedge clk) begin
    sched_reply_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        w = pending_replies.pop_front();
        if (status_code !== w.code)
          report_mismatch("status_code", int'(status_code), int'(w.code));
        if (slot !== w.slot) report_mismatch("slot", int'(slot), int'(w.slot));
        if (pid !== w.pid) report_mismatch("pid", int'(pid), int'(w.pid));
      end
    end
  end

  // watchdog on accepted words
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] rand32();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_word(OP_SCHEDULE, 32'd0, 32'd0);
    send_word(OP_SLEEP, 32'd5, 32'd5);
    send_word(OP_QUERY, 32'd0, 32'd0);
    for (int i = 0; i < NT + 1; i++) send_word(OP_SPAWN, 32'd0, 32'd0);
    send_word(OP_SCHEDULE, 32'd1, 32'd0);
    send_word(OP_SLEEP, 32'd1, 32'd0);
    send_word(OP_SLEEP, 32'hffff_fff0, 32'hffff_ffff);
    send_word(OP_QUERY, 32'hffff_ffff, 32'hffff_ffff);
    send_word(OP_SCHEDULE, 32'hffff_ffff, 32'd0);
  endtask

  task automatic test_random(input int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        send_word(opcode_t'($urandom_range(0, 3)), rand32(), rand32());
      end else begin
        clock_now = clock_now + $urandom_range(0, 40);
        if (k < 40) send_word(OP_SCHEDULE, clock_now, rand32());
        else if (k < 58) send_word(OP_SPAWN, clock_now, $urandom);
        else if (k < 94) send_word(OP_SLEEP, clock_now, $urandom_range(0, 120));
        else send_word(OP_QUERY, clock_now, $urandom);
      end
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(40);
    join
  endtask

  initial begin
    for (int i = 0; i < NT; i++) begin
      m_state[i] = ST_UNUSED;
      m_runs[i] = '0;
      m_wake[i] = '0;
      m_pid[i] = '0;
    end
    m_cur = 0;
    m_cur_ok = 1'b0;
    m_next_pid = FIRST_PID;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(1760);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
